[hw/rtl/alf_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// alf_pkg: shared types, constants and lookups for the lux converter
// Holds the channel payload types, the breakpoint table and the segment
// helpers used by the sequencer, the serial divider and the float encoder.
// ----------------------------------------------------------------------------
package alf_pkg;

   localparam int BYTE_W  = 8;
   localparam int LUX_W   = 16;
   localparam int SEG_W   = 4;
   localparam int NUM_BRK = 15;

   // Serial divider geometry: dividend and quotient share one shift register
   localparam int DIV_W = LUX_W;
   localparam int DVS_W = 4;
   localparam int CNT_W = $clog2(DIV_W);

   // Bus float fields
   localparam int EXP_W  = 4;
   localparam int MANT_W = 11;
   localparam logic [EXP_W-1:0] EXP_INIT = 4'd7;
   localparam logic [EXP_W-1:0] EXP_TOP  = 4'd12;
   localparam logic [LUX_W-1:0] MANT_MAX = 16'h07FF;

   // Saturation
   localparam logic [BYTE_W-1:0] SAT_LIMIT = 8'd112;
   localparam logic [LUX_W-1:0]  SAT_LUX   = 16'hFFFF;

   // Segment numbers that switch the interpolation form
   localparam logic [SEG_W-1:0] SEG_COARSE = 4'd11;
   localparam logic [SEG_W-1:0] SEG_FINE   = 4'd7;
   localparam logic [SEG_W-1:0] SEG_FIRST  = 4'd1;
   localparam logic [SEG_W-1:0] FINE_SHIFT = 4'd6;
   localparam logic [SEG_W-1:0] SH_OFFSET  = 4'd2;

   localparam logic [BYTE_W-1:0] BRK [NUM_BRK] = '{
      8'd0, 8'd9, 8'd17, 8'd27, 8'd40, 8'd53, 8'd66, 8'd79,
      8'd88, 8'd96, 8'd101, 8'd106, 8'd109, 8'd112, 8'd255
   };

   typedef struct packed {
      logic [BYTE_W-1:0] adc_high;
      logic [BYTE_W-1:0] adc_low;
   } req_type;

   typedef struct packed {
      logic [LUX_W-1:0] lux_value;
      logic [LUX_W-1:0] bus_float;
   } rsp_type;

   // Segment number 1..13: count breakpoints at or below the high byte
   function automatic logic [SEG_W-1:0] seg_index(input logic [BYTE_W-1:0] hi);
      logic [SEG_W-1:0] n;
      n = SEG_FIRST;
      for (int k = 1; k < 13; k++) begin
         if (hi >= BRK[k]) n = n + SEG_W'(1);
      end
      return n;
   endfunction

   // Lower breakpoint of segment n
   function automatic logic [BYTE_W-1:0] seg_floor(input logic [SEG_W-1:0] n);
      return BRK[n - SEG_W'(1)];
   endfunction

   // Width of segment n, at most 13
   function automatic logic [DVS_W-1:0] seg_width(input logic [SEG_W-1:0] n);
      logic [BYTE_W-1:0] w;
      w = BRK[n] - BRK[n - SEG_W'(1)];
      return w[DVS_W-1:0];
   endfunction

endpackage

[hw/rtl/alf_div.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// alf_div: bit-serial restoring divider
// Retires one quotient bit per cycle. The dividend shifts
// out of the top of the register while quotient bits shift in at the bottom.
// ----------------------------------------------------------------------------
module alf_div
   import alf_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [DIV_W-1:0] dividend,
   input  logic [DVS_W-1:0] divisor,
   output logic             done,
   output logic [DIV_W-1:0] quotient
);

   typedef enum logic {D_IDLE, D_RUN} state_type;

   state_type        state_ff, state_in;
   logic [DIV_W-1:0] acc_ff, acc_in;
   logic [DVS_W-1:0] rem_ff, rem_in;
   logic [DVS_W-1:0] dvs_ff, dvs_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             done_ff, done_in;
   logic [DVS_W:0]   trial;
   logic [DVS_W:0]   diff;
   logic             fits;

   // Bring down the next dividend bit and try the subtraction
   assign trial = {rem_ff, acc_ff[DIV_W-1]};
   assign diff  = trial - {1'b0, dvs_ff};
   assign fits  = trial >= {1'b0, dvs_ff};

   always_comb begin
      state_in = state_ff;
      acc_in   = acc_ff;
      rem_in   = rem_ff;
      dvs_in   = dvs_ff;
      cnt_in   = cnt_ff;
      done_in  = 1'b0;
      case (state_ff)
         D_IDLE: begin
            if (start) begin
               acc_in   = dividend;
               rem_in   = '0;
               dvs_in   = divisor;
               cnt_in   = '0;
               state_in = D_RUN;
            end
         end
         D_RUN: begin
            acc_in = {acc_ff[DIV_W-2:0], fits};
            rem_in = fits ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
            cnt_in = cnt_ff + CNT_W'(1);
            if (cnt_ff == CNT_W'(DIV_W - 1)) begin
               state_in = D_IDLE;
               done_in  = 1'b1;
            end
         end
         default: begin
            state_in = D_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= D_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
      acc_ff <= acc_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
      cnt_ff <= cnt_in;
   end

   assign done     = done_ff;
   assign quotient = acc_ff;

   // Partial remainder stays below the divisor while running
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == D_RUN) |-> (rem_ff < dvs_ff))
      else $error("divider remainder not below divisor");

   // A new division is only launched on an idle divider
   assert property (@(posedge clock) disable iff (reset)
      start |-> (state_ff == D_IDLE))
      else $error("divider started while busy");

endmodule

[hw/rtl/alf_float.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// alf_float: two-byte bus float encoder
// Scales lux by 0.78125 into a mantissa at exponent 7, then shifts right one
// bit per cycle, bumping the exponent, until the mantissa fits in 11 bits.
// ----------------------------------------------------------------------------
module alf_float
   import alf_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [LUX_W-1:0] lux,
   output logic             done,
   output logic [LUX_W-1:0] result
);

   typedef enum logic {F_IDLE, F_NORM} state_type;

   state_type        state_ff, state_in;
   logic [LUX_W-1:0] mant_ff, mant_in;
   logic [EXP_W-1:0] exp_ff, exp_in;
   logic             done_ff, done_in;
   logic [LUX_W-1:0] scaled;

   // Truncated 1/2 + 1/4 + 1/32 scaling
   assign scaled = (lux >> 1) + (lux >> 2) + (lux >> 5);

   always_comb begin
      state_in = state_ff;
      mant_in  = mant_ff;
      exp_in   = exp_ff;
      done_in  = 1'b0;
      case (state_ff)
         F_IDLE: begin
            if (start) begin
               mant_in  = scaled;
               exp_in   = EXP_INIT;
               state_in = F_NORM;
            end
         end
         F_NORM: begin
            // Shift until the mantissa fits, then hold the result
            if (mant_ff > MANT_MAX) begin
               mant_in = mant_ff >> 1;
               exp_in  = exp_ff + EXP_W'(1);
            end else begin
               state_in = F_IDLE;
               done_in  = 1'b1;
            end
         end
         default: begin
            state_in = F_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= F_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
      mant_ff <= mant_in;
      exp_ff  <= exp_in;
   end

   assign done   = done_ff;
   assign result = {1'b0, exp_ff, mant_ff[MANT_W-1:0]};

   // Largest lux normalizes at exponent 12, so the exponent tops out at 12
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == F_NORM) |-> (exp_ff <= EXP_TOP))
      else $error("bus float exponent out of range");

endmodule

[hw/rtl/adc_to_lux_bus_float_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// adc_to_lux_bus_float_top: light sensor reading to lux and bus float
// The request passes segment lookup, bit-serial division, the sum and the
// serial float normalize, then waits until the output register is free.
// One transaction at a time, requests stall until it is done; a new request is taken
// while a finished response still waits in the output register.
// Reset: synchronous, clears the sequencer and the response valid.
// ----------------------------------------------------------------------------
module adc_to_lux_bus_float_top
   import alf_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   typedef enum logic [2:0] {
      ST_IDLE, ST_SEG, ST_DIV, ST_SUM, ST_FLT, ST_OUT
   } state_type;

   state_type         state_ff, state_in;
   logic [BYTE_W-1:0] hi_ff, hi_in;
   logic [BYTE_W-1:0] lo_ff, lo_in;
   logic [SEG_W-1:0]  n_ff, n_in;
   logic              sat_ff, sat_in;
   logic [LUX_W-1:0]  lux_ff, lux_in;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_type           rsp_data_ff, rsp_data_in;

   logic [SEG_W-1:0]  seg_n;
   logic [BYTE_W-1:0] rest;
   logic [SEG_W-1:0]  shamt;
   logic [DVS_W-1:0]  width;
   logic [DIV_W-1:0]  coarse_dvd;
   logic [DIV_W-1:0]  fine_dvd;
   logic              div_start;
   logic              div_done;
   logic              fine_done;
   logic [DIV_W-1:0]  coarse_q;
   logic [DIV_W-1:0]  fine_q;
   logic [LUX_W-1:0]  base;
   logic [LUX_W-1:0]  interp;
   logic [LUX_W-1:0]  fine_add;
   logic [LUX_W-1:0]  lux_calc;
   logic              flt_start;
   logic              flt_done;
   logic [LUX_W-1:0]  flt_result;
   logic              rsp_free;

   // Locate the segment and form both dividends
   assign seg_n      = seg_index(hi_ff);
   assign rest       = hi_ff - seg_floor(seg_n);
   assign width      = seg_width(seg_n);
   assign shamt      = (seg_n < SEG_COARSE) ? seg_n + SH_OFFSET : seg_n - SH_OFFSET;
   assign coarse_dvd = LUX_W'(rest) << shamt;
   assign fine_dvd   = (seg_n < SEG_FINE) ? LUX_W'(lo_ff >> (FINE_SHIFT - seg_n)) : '0;
   assign div_start  = (state_ff == ST_SEG);

   alf_div u_div_coarse (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (coarse_dvd),
      .divisor  (width),
      .done     (div_done),
      .quotient (coarse_q)
   );

   alf_div u_div_fine (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (fine_dvd),
      .divisor  (width),
      .done     (fine_done),
      .quotient (fine_q)
   );

   // Combine base, segment interpolation and low-byte fraction
   assign base     = (n_ff <= SEG_FIRST) ? '0 : LUX_W'(2) << n_ff;
   assign interp   = (n_ff < SEG_COARSE) ? coarse_q : coarse_q << 4;
   assign fine_add = (n_ff < SEG_FINE) ? fine_q : '0;
   assign lux_calc = sat_ff ? SAT_LUX : base + interp + fine_add;
   assign flt_start = (state_ff == ST_SUM);

   alf_float u_float (
      .clock  (clock),
      .reset  (reset),
      .start  (flt_start),
      .lux    (lux_calc),
      .done   (flt_done),
      .result (flt_result)
   );

   assign rsp_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      state_in     = state_ff;
      hi_in        = hi_ff;
      lo_in        = lo_ff;
      n_in         = n_ff;
      sat_in       = sat_ff;
      lux_in       = lux_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               hi_in    = req_data.adc_high;
               lo_in    = req_data.adc_low;
               state_in = ST_SEG;
            end
         end
         ST_SEG: begin
            n_in     = seg_n;
            sat_in   = hi_ff >= SAT_LIMIT;
            state_in = ST_DIV;
         end
         ST_DIV: begin
            if (div_done) state_in = ST_SUM;
         end
         ST_SUM: begin
            lux_in   = lux_calc;
            state_in = ST_FLT;
         end
         ST_FLT: begin
            if (flt_done) state_in = ST_OUT;
         end
         ST_OUT: begin
            // Load the response once the output register is free
            if (rsp_free) begin
               rsp_data_in.lux_value = lux_ff;
               rsp_data_in.bus_float = flt_result;
               rsp_valid_in          = 1'b1;
               state_in              = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      hi_ff       <= hi_in;
      lo_ff       <= lo_in;
      n_ff        <= n_in;
      sat_ff      <= sat_in;
      lux_ff      <= lux_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // Divider completion only while the sequencer waits for it
   assert property (@(posedge clock) disable iff (reset)
      div_done |-> (state_ff == ST_DIV && fine_done))
      else $error("divider finished outside divide step");

   // Float completion only while the sequencer waits for it
   assert property (@(posedge clock) disable iff (reset)
      flt_done |-> (state_ff == ST_FLT))
      else $error("float encoder finished outside encode step");

endmodule
